// ===== design/glw_pkg.sv =====
package glw_pkg;

    localparam logic [7:0] CHAR_END     = 8'd0;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    localparam logic [7:0] CNT_MAX = 8'd255;
    localparam logic [9:0] PIX_MAX = 10'd1023;

    // Configuration register indexes.
    localparam logic REG_BOX_WIDTH     = 1'b0;
    localparam logic REG_GLYPH_ADVANCE = 1'b1;

    localparam logic [7:0] BOX_WIDTH_RESET     = 8'd128;
    localparam logic [3:0] GLYPH_ADVANCE_RESET = 4'd6;

    typedef struct packed {
        logic [7:0] box_width;
        logic [3:0] glyph_advance;
    } cfg_t;

    typedef struct packed {
        logic [7:0] line_length;
        logic [7:0] skipped_spaces;
        logic       text_done;
    } result_t;

endpackage

// ===== design/glw_scan.sv =====
module glw_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        char_code,
    input  logic              line_start,
    input  glw_pkg::cfg_t     cfg,
    output logic              has_result,
    output glw_pkg::result_t  result
);

    logic [7:0] chars_reg, chars_next;
    logic [9:0] pixels_reg, pixels_next;
    logic [7:0] gap_reg, gap_next;
    logic [7:0] break_reg, break_next;
    logic [7:0] leading_reg, leading_next;
    logic       done_reg, done_next;

    logic [7:0]  chars_cur, gap_cur, break_cur, leading_cur;
    logic [9:0]  pixels_cur;
    logic        done_cur;
    logic [8:0]  gap_plus;
    logic [9:0]  chars_sum;
    logic [7:0]  chars_new;
    logic [12:0] gap_pixels;
    logic [13:0] pix_sum;
    logic [9:0]  pix_new;
    logic [9:0]  box_limit;

    always_comb
    begin
        // A start clears the scan state before this character is looked at.
        chars_cur   = line_start ? 8'd0 : chars_reg;
        pixels_cur  = line_start ? 10'd0 : pixels_reg;
        gap_cur     = line_start ? 8'd0 : gap_reg;
        break_cur   = line_start ? 8'd0 : break_reg;
        leading_cur = line_start ? 8'd0 : leading_reg;
        done_cur    = line_start ? 1'b0 : done_reg;

        gap_plus   = {1'b0, gap_cur} + 9'd1;
        chars_sum  = {2'b00, chars_cur} + {1'b0, gap_plus};
        chars_new  = (chars_sum > {2'b00, glw_pkg::CNT_MAX}) ? glw_pkg::CNT_MAX
                                                            : chars_sum[7:0];
        gap_pixels = gap_plus * cfg.glyph_advance;
        pix_sum    = {4'd0, pixels_cur} + {1'b0, gap_pixels};
        pix_new    = (pix_sum > {4'd0, glw_pkg::PIX_MAX}) ? glw_pkg::PIX_MAX
                                                          : pix_sum[9:0];
        box_limit  = {2'b00, cfg.box_width} + 10'd1;

        chars_next   = chars_cur;
        pixels_next  = pixels_cur;
        gap_next     = gap_cur;
        break_next   = break_cur;
        leading_next = leading_cur;
        done_next    = done_cur;

        has_result            = 1'b0;
        result.line_length    = chars_cur;
        result.skipped_spaces = leading_cur;
        result.text_done      = 1'b0;

        if (!done_cur)
        begin
            if (char_code == glw_pkg::CHAR_END)
            begin
                has_result       = 1'b1;
                result.text_done = 1'b1;
                done_next        = 1'b1;
            end
            else if (char_code == glw_pkg::CHAR_NEWLINE)
            begin
                // The newline itself counts as one character of the line.
                has_result         = 1'b1;
                result.line_length = (chars_cur == glw_pkg::CNT_MAX) ? glw_pkg::CNT_MAX
                                                                     : chars_cur + 8'd1;
                done_next          = 1'b1;
            end
            else if (char_code <= glw_pkg::CHAR_SPACE)
            begin
                if (chars_cur == 8'd0)
                begin
                    if (leading_cur != glw_pkg::CNT_MAX)
                    begin
                        leading_next = leading_cur + 8'd1;
                    end
                end
                else
                begin
                    if (gap_cur == 8'd0)
                    begin
                        break_next = chars_cur;
                    end
                    if (gap_cur != glw_pkg::CNT_MAX)
                    begin
                        gap_next = gap_cur + 8'd1;
                    end
                end
            end
            else
            begin
                // A visible character pulls in the pending gap ahead of it.
                chars_next  = chars_new;
                pixels_next = pix_new;
                gap_next    = 8'd0;
                if (pix_new > box_limit)
                begin
                    has_result = 1'b1;
                    done_next  = 1'b1;
                    // Without a space to break at, the word is split before its
                    // last character.
                    result.line_length = (break_cur != 8'd0) ? break_cur
                                                             : chars_new - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg   <= 8'd0;
            pixels_reg  <= 10'd0;
            gap_reg     <= 8'd0;
            break_reg   <= 8'd0;
            leading_reg <= 8'd0;
            done_reg    <= 1'b1;
        end
        else if (step)
        begin
            chars_reg   <= chars_next;
            pixels_reg  <= pixels_next;
            gap_reg     <= gap_next;
            break_reg   <= break_next;
            leading_reg <= leading_next;
            done_reg    <= done_next;
        end
    end

endmodule

// ===== design/greedy_word_wrap_line_finder.sv =====
// Greedy word-wrap line finder: unless stalled, text enters one character item
// per clock and, once a line ends (zero byte, newline or box width overflowed),
// one result item gives the line length, the leading spaces skipped and an
// end-of-text flag. It sustains one character per cycle while the receiver does
// not stall; a character passes an input register and the scan logic, and its
// result enters the output register when the character is scanned. The output
// register holds a result while the receiver stalls; then the input register
// takes one more character and the input stalls until the result leaves.
module greedy_word_wrap_line_finder (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_code,
    input  logic       line_start,

    output logic       line_valid,
    input  logic       line_stall,
    output logic [7:0] line_length,
    output logic [7:0] skipped_spaces,
    output logic       text_done
);

    glw_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       in_code_reg;
    logic             in_start_reg;
    logic             out_valid_reg;
    glw_pkg::result_t out_reg;

    logic             step;
    logic             has_result;
    glw_pkg::result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_width     <= glw_pkg::BOX_WIDTH_RESET;
            cfg_reg.glyph_advance <= glw_pkg::GLYPH_ADVANCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                glw_pkg::REG_BOX_WIDTH:     cfg_reg.box_width     <= cfg_data;
                glw_pkg::REG_GLYPH_ADVANCE: cfg_reg.glyph_advance <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // The held item is scanned once the output register can take its result.
    assign step       = in_valid_reg && (!out_valid_reg || !line_stall);
    assign char_stall = in_valid_reg && !step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            in_code_reg  <= char_code;
            in_start_reg <= line_start;
        end
    end

    glw_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .char_code  (in_code_reg),
        .line_start (in_start_reg),
        .cfg        (cfg_reg),
        .has_result (has_result),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!line_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && has_result)
        begin
            out_reg <= result;
        end
    end

    assign line_valid     = out_valid_reg;
    assign line_length    = out_reg.line_length;
    assign skipped_spaces = out_reg.skipped_spaces;
    assign text_done      = out_reg.text_done;

endmodule
